// ----- design/bcf_pkg.sv -----
// shared types and constants of the bezier curve flattener
package bcf_pkg;

	// segment mode codes
	localparam logic [1:0] MODE_MOVE  = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_QUAD  = 2'd2;
	localparam logic [1:0] MODE_CUBIC = 2'd3;

	// tolerance register
	localparam int unsigned TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd128;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;      // load a new request, update pen
		logic load_cubic;  // new request is a cubic
		logic st1;         // first midpoints and chord midpoint
		logic st2;         // second level midpoints
		logic st3;         // curve midpoint
		logic st4;         // deviation magnitudes
		logic st5;         // squares
		logic split;       // push right half, descend into left half
		logic emit;        // load output segment, pop if stack not empty
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic tol_ok;         // squared deviation within tolerance
		logic split_to_max;   // a split now reaches the depth limit
		logic pop_level_max;  // top stack entry sits at the depth limit
		logic stack_empty;    // no pending halves
		logic out_free;       // output register can take a segment
	} status_t;

endpackage

// ----- design/bcf_ctrl.sv -----
// controller state machine of the bezier curve flattener
module bcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        mode,
	output logic              in_stall,
	input  bcf_pkg::status_t  st,
	output bcf_pkg::cmd_t     cmd
);
	import bcf_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EV1    = 8'b0000_0010,
		S_EV2    = 8'b0000_0100,
		S_EV3    = 8'b0000_1000,
		S_EV4    = 8'b0001_0000,
		S_EV5    = 8'b0010_0000,
		S_DECIDE = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request taken only when idle
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept     = 1'b1;
					cmd.load_cubic = (mode == MODE_CUBIC);
					unique case (mode) inside
						MODE_MOVE:              state_d = S_IDLE;
						MODE_LINE:              state_d = S_EMIT;
						MODE_QUAD, MODE_CUBIC:  state_d = S_EV1;
						default:                state_d = S_IDLE;
					endcase
				end
			end
			S_EV1: begin
				cmd.st1 = 1'b1;
				state_d = S_EV2;
			end
			S_EV2: begin
				cmd.st2 = 1'b1;
				state_d = S_EV3;
			end
			S_EV3: begin
				cmd.st3 = 1'b1;
				state_d = S_EV4;
			end
			S_EV4: begin
				cmd.st4 = 1'b1;
				state_d = S_EV5;
			end
			S_EV5: begin
				cmd.st5 = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.tol_ok) begin
					state_d = S_EMIT;
				end else begin
					cmd.split = 1'b1;
					state_d   = st.split_to_max ? S_EMIT : S_EV1;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.stack_empty) begin
						state_d = S_IDLE;
					end else begin
						state_d = st.pop_level_max ? S_EMIT : S_EV1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/bcf_datapath.sv -----
// datapath of the bezier curve flattener: points, subdivision stack, flatness test
module bcf_datapath #(
	parameter int MAX_DEPTH   = 6,
	parameter int COORD_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcf_pkg::TOL_W-1:0]           cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0]       ctrl1_x,
	input  logic signed [COORD_WIDTH-1:0]       ctrl1_y,
	input  logic signed [COORD_WIDTH-1:0]       ctrl2_x,
	input  logic signed [COORD_WIDTH-1:0]       ctrl2_y,
	input  logic signed [COORD_WIDTH-1:0]       end_x,
	input  logic signed [COORD_WIDTH-1:0]       end_y,
	input  bcf_pkg::cmd_t                       cmd,
	output bcf_pkg::status_t                    st,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_WIDTH-1:0]       from_x,
	output logic signed [COORD_WIDTH-1:0]       from_y,
	output logic signed [COORD_WIDTH-1:0]       to_x,
	output logic signed [COORD_WIDTH-1:0]       to_y,
	output logic                                last
);
	import bcf_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int MAG_W = CW + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int ERR_W = SQ_W + 1;
	localparam int TSQ_W = 2 * TOL_W;
	localparam int CMP_W = (ERR_W > TSQ_W) ? ERR_W : TSQ_W;

	typedef logic signed [CW-1:0] crd_t;

	// floor of (a + b) / 2
	function automatic crd_t mid(input crd_t a, input crd_t b);
		logic signed [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		return crd_t'(s[CW:1]);
	endfunction

	// magnitude of a - b
	function automatic logic [MAG_W-1:0] absdiff(input crd_t a, input crd_t b);
		logic signed [CW:0] d;
		logic signed [CW:0] nd;
		d  = {a[CW-1], a} - {b[CW-1], b};
		nd = {b[CW-1], b} - {a[CW-1], a};
		return d[CW] ? nd : d;
	endfunction

	// configuration and pen
	logic [TOL_W-1:0] tol_q;
	crd_t             pen_x_q, pen_y_q;

	// current piece
	crd_t             p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q;
	logic             cubic_q;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] top_q;

	// subdivision stack
	crd_t             stk_c1x_q [MAX_DEPTH];
	crd_t             stk_c1y_q [MAX_DEPTH];
	crd_t             stk_c2x_q [MAX_DEPTH];
	crd_t             stk_c2y_q [MAX_DEPTH];
	crd_t             stk_ex_q  [MAX_DEPTH];
	crd_t             stk_ey_q  [MAX_DEPTH];
	logic [LVL_W-1:0] stk_lvl_q [MAX_DEPTH];

	// evaluation stages
	crd_t             m01x_s1, m01y_s1, m12x_s1, m12y_s1, m23x_s1, m23y_s1, chx_s1, chy_s1;
	crd_t             m012x_s2, m012y_s2, m123x_s2, m123y_s2;
	crd_t             cmx_s3, cmy_s3;
	logic [MAG_W-1:0] dx_s4, dy_s4;
	logic [SQ_W-1:0]  sqx_s5, sqy_s5;
	logic [TSQ_W-1:0] tol2_s5;

	// output register
	logic             out_valid_q;
	crd_t             from_x_q, from_y_q, to_x_q, to_y_q;
	logic             last_q;

	crd_t             endx, endy;
	logic [LVL_W-1:0] top_m1;
	logic [IDX_W-1:0] rd_idx, wr_idx;
	logic [ERR_W-1:0] err;

	assign endx   = cubic_q ? p3x_q : p2x_q;
	assign endy   = cubic_q ? p3y_q : p2y_q;
	assign top_m1 = top_q - LVL_W'(1);
	assign rd_idx = top_m1[IDX_W-1:0];
	assign wr_idx = top_q[IDX_W-1:0];
	assign err    = {1'b0, sqx_s5} + {1'b0, sqy_s5};

	// status
	assign st.tol_ok        = CMP_W'(err) <= CMP_W'(tol2_s5);
	assign st.split_to_max  = (level_q == LVL_W'(MAX_DEPTH - 1));
	assign st.pop_level_max = (stk_lvl_q[rd_idx] == LVL_W'(MAX_DEPTH));
	assign st.stack_empty   = (top_q == '0);
	assign st.out_free      = !out_valid_q || !out_stall;

	// tolerance register and pen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				pen_x_q <= end_x;
				pen_y_q <= end_y;
			end
		end
	end

	// piece control: level and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			top_q   <= '0;
		end else if (cmd.accept) begin
			level_q <= '0;
			top_q   <= '0;
		end else if (cmd.split) begin
			level_q <= level_q + LVL_W'(1);
			top_q   <= top_q + LVL_W'(1);
		end else if (cmd.emit && (top_q != '0)) begin
			level_q <= stk_lvl_q[rd_idx];
			top_q   <= top_m1;
		end
	end

	// current piece points
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cubic_q <= cmd.load_cubic;
			p0x_q   <= pen_x_q;
			p0y_q   <= pen_y_q;
			p1x_q   <= ctrl1_x;
			p1y_q   <= ctrl1_y;
			p2x_q   <= cmd.load_cubic ? ctrl2_x : end_x;
			p2y_q   <= cmd.load_cubic ? ctrl2_y : end_y;
			p3x_q   <= end_x;
			p3y_q   <= end_y;
		end else if (cmd.split) begin
			p1x_q <= m01x_s1;
			p1y_q <= m01y_s1;
			if (cubic_q) begin
				p2x_q <= m012x_s2;
				p2y_q <= m012y_s2;
				p3x_q <= cmx_s3;
				p3y_q <= cmy_s3;
			end else begin
				p2x_q <= cmx_s3;
				p2y_q <= cmy_s3;
			end
		end else if (cmd.emit && (top_q != '0)) begin
			p0x_q <= endx;
			p0y_q <= endy;
			p1x_q <= stk_c1x_q[rd_idx];
			p1y_q <= stk_c1y_q[rd_idx];
			p2x_q <= stk_c2x_q[rd_idx];
			p2y_q <= stk_c2y_q[rd_idx];
			p3x_q <= stk_ex_q[rd_idx];
			p3y_q <= stk_ey_q[rd_idx];
		end
	end

	// push right half on split
	always_ff @(posedge clk) begin
		if (cmd.split) begin
			stk_c1x_q[wr_idx] <= cubic_q ? m123x_s2 : m12x_s1;
			stk_c1y_q[wr_idx] <= cubic_q ? m123y_s2 : m12y_s1;
			stk_c2x_q[wr_idx] <= cubic_q ? m23x_s1 : p2x_q;
			stk_c2y_q[wr_idx] <= cubic_q ? m23y_s1 : p2y_q;
			stk_ex_q[wr_idx]  <= p3x_q;
			stk_ey_q[wr_idx]  <= p3y_q;
			stk_lvl_q[wr_idx] <= level_q + LVL_W'(1);
		end
	end

	// flatness evaluation pipeline, one stage per command
	always_ff @(posedge clk) begin
		if (cmd.st1) begin
			m01x_s1 <= mid(p0x_q, p1x_q);
			m01y_s1 <= mid(p0y_q, p1y_q);
			m12x_s1 <= mid(p1x_q, p2x_q);
			m12y_s1 <= mid(p1y_q, p2y_q);
			m23x_s1 <= mid(p2x_q, p3x_q);
			m23y_s1 <= mid(p2y_q, p3y_q);
			chx_s1  <= mid(p0x_q, endx);
			chy_s1  <= mid(p0y_q, endy);
		end
		if (cmd.st2) begin
			m012x_s2 <= mid(m01x_s1, m12x_s1);
			m012y_s2 <= mid(m01y_s1, m12y_s1);
			m123x_s2 <= mid(m12x_s1, m23x_s1);
			m123y_s2 <= mid(m12y_s1, m23y_s1);
		end
		if (cmd.st3) begin
			cmx_s3 <= cubic_q ? mid(m012x_s2, m123x_s2) : m012x_s2;
			cmy_s3 <= cubic_q ? mid(m012y_s2, m123y_s2) : m012y_s2;
		end
		if (cmd.st4) begin
			dx_s4 <= absdiff(cmx_s3, chx_s1);
			dy_s4 <= absdiff(cmy_s3, chy_s1);
		end
		if (cmd.st5) begin
			sqx_s5  <= SQ_W'(dx_s4) * SQ_W'(dx_s4);
			sqy_s5  <= SQ_W'(dy_s4) * SQ_W'(dy_s4);
			tol2_s5 <= TSQ_W'(tol_q) * TSQ_W'(tol_q);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			from_x_q <= p0x_q;
			from_y_q <= p0y_q;
			to_x_q   <= endx;
			to_y_q   <= endy;
			last_q   <= (top_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign from_x    = from_x_q;
	assign from_y    = from_y_q;
	assign to_x      = to_x_q;
	assign to_y      = to_y_q;
	assign last      = last_q;

	// a segment is never loaded over one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("segment loaded into a full output register");

	// no split at the depth limit, so the stack cannot overflow
	a_split_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.split |-> (level_q < LVL_W'(MAX_DEPTH)) && (top_q < LVL_W'(MAX_DEPTH)))
		else $error("split beyond depth limit");

	// pending halves never outnumber the level of the current piece
	a_top_le_level: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= level_q)
		else $error("stack deeper than current level");

endmodule

// ----- design/bezier_curve_flattener_core.sv -----
// top level of the bezier curve flattener: controller and datapath
// a move only sets the pen; a line is accepted, then emitted once the output is free
// curves: accept, then per tested piece 5-stage midpoint and square evaluation plus
// decision, and one emit per segment; at most 63 tested pieces, 64 segments per curve
// a new request is taken only once the previous one has issued all its segments
// reset: asynchronous, clears pen to zero, tolerance to 128, empties the stack
module bezier_curve_flattener_core #(
	parameter int MAX_DEPTH   = 6,
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcf_pkg::TOL_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic signed [COORD_WIDTH-1:0] ctrl1_x,
	input  logic signed [COORD_WIDTH-1:0] ctrl1_y,
	input  logic signed [COORD_WIDTH-1:0] ctrl2_x,
	input  logic signed [COORD_WIDTH-1:0] ctrl2_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] from_x,
	output logic signed [COORD_WIDTH-1:0] from_y,
	output logic signed [COORD_WIDTH-1:0] to_x,
	output logic signed [COORD_WIDTH-1:0] to_y,
	output logic                          last
);
	import bcf_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencing
	bcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// arithmetic, stack and output register
	bcf_datapath #(
		.MAX_DEPTH   (MAX_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl1_x   (ctrl1_x),
		.ctrl1_y   (ctrl1_y),
		.ctrl2_x   (ctrl2_x),
		.ctrl2_y   (ctrl2_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.last      (last)
	);

endmodule
